/* rtl/btcd_pkg.sv */
`timescale 1ns / 1ps
// Shared types, codes and constants of the block time check and difficulty core.
package btcd_pkg;

	localparam int unsigned MEDIAN_WINDOW_DEF = 11;
	localparam int unsigned EPOCH_BLOCKS_DEF  = 1024;
	localparam int unsigned TIME_W            = 40;
	localparam int unsigned DIFF_W            = 32;
	localparam int unsigned SPACING_W         = 20;
	localparam int unsigned STEPS_W           = 8;
	localparam int unsigned CFG_IDX_W         = 3;
	localparam int unsigned CFG_DATA_W        = 32;
	localparam int unsigned ALU_W             = 64;
	localparam int unsigned QUO_W             = 36;
	localparam int unsigned DVD_W             = 79;

	localparam logic [1:0] TS_OK  = 2'd0;
	localparam logic [1:0] TS_OLD = 2'd1;
	localparam logic [1:0] TS_NEW = 2'd2;

	localparam logic OP_APPEND = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SPACING,
		CFG_HALF_LIFE,
		CFG_DOWN_STEPS,
		CFG_UP_STEPS,
		CFG_MIN_DIFF,
		CFG_MAX_DIFF,
		CFG_FUTURE_DRIFT,
		CFG_GENESIS
	} cfg_idx_t;

	typedef struct packed {
		logic [SPACING_W-1:0] spacing;
		logic [31:0]          half_life;
		logic [STEPS_W-1:0]   down_steps;
		logic [STEPS_W-1:0]   up_steps;
		logic [DIFF_W-1:0]    min_diff;
		logic [DIFF_W-1:0]    max_diff;
		logic [31:0]          future_drift;
		logic [DIFF_W-1:0]    genesis;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0] median;
		logic [1:0]        status;
		logic [DIFF_W-1:0] difficulty;
	} res_t;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		alu_op_t          op;
		logic [ALU_W-1:0] a;
		logic [ALU_W-1:0] b;
	} alu_req_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_UPD,
		S_MC,
		S_ML,
		S_MS,
		S_ME,
		S_SUM,
		S_CMP1,
		S_CMP2,
		S_ND0,
		S_MUL,
		S_D1,
		S_TD,
		S_ABS,
		S_DIV,
		S_UNC,
		S_DC,
		S_UC,
		S_CL1,
		S_CL2,
		S_CL3,
		S_CL4,
		S_DONE
	} state_t;

endpackage

/* rtl/btcd_alu.sv */
`timescale 1ns / 1ps
// Shared 64-bit signed add/subtract unit with signed less-than flag.
module btcd_alu (
	input  btcd_pkg::alu_req_t           req,
	output logic [btcd_pkg::ALU_W-1:0]   sum,
	output logic                         lt
);

	logic [btcd_pkg::ALU_W:0] ea;
	logic [btcd_pkg::ALU_W:0] eb;
	logic [btcd_pkg::ALU_W:0] r;

	assign ea  = {req.a[btcd_pkg::ALU_W-1], req.a};
	assign eb  = {req.b[btcd_pkg::ALU_W-1], req.b};
	assign r   = (req.op == btcd_pkg::ALU_SUB) ? (ea - eb) : (ea + eb);
	assign sum = r[btcd_pkg::ALU_W-1:0];
	// sign of the exact difference: a < b on a subtract
	assign lt  = r[btcd_pkg::ALU_W];

endmodule

/* rtl/btcd_ring.sv */
`timescale 1ns / 1ps
// Ring memory of recent block times, one write and one registered read port.
module btcd_ring #(
	parameter int unsigned MEDIAN_WINDOW = btcd_pkg::MEDIAN_WINDOW_DEF,
	parameter int unsigned IW            = (MEDIAN_WINDOW > 1) ? $clog2(MEDIAN_WINDOW) : 1
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [IW-1:0]               waddr,
	input  logic [btcd_pkg::TIME_W-1:0] wdata,
	input  logic [IW-1:0]               raddr,
	output logic [btcd_pkg::TIME_W-1:0] rdata_q
);

	logic [btcd_pkg::TIME_W-1:0] mem_q [MEDIAN_WINDOW];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

/* rtl/btcd_core.sv */
`timescale 1ns / 1ps
// Sequencer and datapath: chain state, median rank scan, ASERT step and clamps.
module btcd_core #(
	parameter int unsigned MEDIAN_WINDOW = btcd_pkg::MEDIAN_WINDOW_DEF,
	parameter int unsigned EPOCH_BLOCKS  = btcd_pkg::EPOCH_BLOCKS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  btcd_pkg::cfg_t              cfg,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        in_op,
	input  logic [btcd_pkg::TIME_W-1:0] in_bt,
	input  logic [btcd_pkg::DIFF_W-1:0] in_bd,
	input  logic [btcd_pkg::TIME_W-1:0] in_now,
	input  logic                        res_take,
	output logic                        res_valid,
	output btcd_pkg::res_t              res
);

	localparam int unsigned W  = MEDIAN_WINDOW;
	localparam int unsigned IW = (W > 1) ? $clog2(W) : 1;
	localparam int unsigned NW = $clog2(W + 1);
	localparam int unsigned AW = $clog2(2 * W);
	localparam int unsigned EW = (EPOCH_BLOCKS > 1) ? $clog2(EPOCH_BLOCKS) : 1;
	localparam int unsigned TW = btcd_pkg::TIME_W;
	localparam int unsigned DW = btcd_pkg::DIFF_W;
	localparam int unsigned XW = btcd_pkg::ALU_W;
	localparam int unsigned QW = btcd_pkg::QUO_W;
	localparam int unsigned VW = btcd_pkg::DVD_W;

	btcd_pkg::state_t state_q, state_d;

	logic          op_q;
	logic [TW-1:0] bt_q, now_q;
	logic [DW-1:0] bd_q;

	logic [IW-1:0] ptr_q;
	logic [TW-1:0] count_q;
	logic [EW-1:0] epc_q;
	logic [TW-1:0] last_t_q, anc_t_q, anc_i_q;
	logic [DW-1:0] last_d_q, anc_d_q;

	logic [IW-1:0] i_q, j_q;
	logic [NW-1:0] cnt_q;
	logic [TW-1:0] cand_q, med_q;
	logic [1:0]    stat_q;
	logic [XW-1:0] sum_q, acc_q, td_q, unc_q, dc_q, r_q;
	logic [TW-1:0] nn_q;
	logic [4:0]    k_q;
	logic          neg_q, sat_q;
	logic [VW-1:0] dvd_q;
	logic [31:0]   rem_q;
	logic [QW-1:0] quo_q;
	logic [6:0]    dk_q;

	btcd_pkg::alu_req_t alu_req;
	logic [XW-1:0]      alu_sum;
	logic               alu_lt;

	logic          ring_we;
	logic [IW-1:0] ring_raddr;
	logic [TW-1:0] ring_rdata;

	logic [NW-1:0] nwin;
	logic          live_j, live_i;
	logic [DW-1:0] adiff;
	logic [QW-1:0] adj_mag;
	logic [32:0]   div_t;

	btcd_alu u_alu (
		.req (alu_req),
		.sum (alu_sum),
		.lt  (alu_lt)
	);

	btcd_ring #(
		.MEDIAN_WINDOW (W),
		.IW            (IW)
	) u_ring (
		.clk     (clk),
		.we      (ring_we),
		.waddr   (ptr_q),
		.wdata   (bt_q),
		.raddr   (ring_raddr),
		.rdata_q (ring_rdata)
	);

	// an entry is live when its age behind the write pointer is below the fill
	function automatic logic is_live(input logic [IW-1:0] idx, input logic [IW-1:0] ptr,
			input logic [NW-1:0] n);
		logic [AW-1:0] age;
		age = AW'(ptr) + AW'(W - 1) - AW'(idx);
		if (age >= AW'(W)) begin
			age = age - AW'(W);
		end
		return (AW'(n) > age);
	endfunction

	assign nwin    = (count_q < TW'(W)) ? count_q[NW-1:0] : NW'(W);
	assign live_j  = is_live(j_q, ptr_q, nwin);
	assign live_i  = is_live(i_q, ptr_q, nwin);
	assign adiff   = (anc_d_q != '0) ? anc_d_q : last_d_q;
	assign adj_mag = (sat_q || quo_q[QW-1]) ? {1'b1, {(QW-1){1'b0}}} : quo_q;
	assign div_t   = {rem_q, dvd_q[VW-1]};

	assign in_ready  = (state_q == btcd_pkg::S_IDLE);
	assign res_valid = (state_q == btcd_pkg::S_DONE);
	assign res.median     = med_q;
	assign res.status     = stat_q;
	assign res.difficulty = r_q[DW-1:0];
	assign ring_we = (state_q == btcd_pkg::S_UPD) && (op_q == btcd_pkg::OP_APPEND);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			btcd_pkg::S_IDLE: if (in_valid) state_d = btcd_pkg::S_UPD;
			btcd_pkg::S_UPD:  state_d = btcd_pkg::S_MC;
			btcd_pkg::S_MC:   state_d = (count_q == '0) ? btcd_pkg::S_SUM : btcd_pkg::S_ML;
			btcd_pkg::S_ML:   state_d = btcd_pkg::S_MS;
			btcd_pkg::S_MS:   if (j_q == IW'(W - 1)) state_d = btcd_pkg::S_ME;
			btcd_pkg::S_ME: begin
				if (live_i && (cnt_q == (nwin >> 1))) state_d = btcd_pkg::S_SUM;
				else state_d = btcd_pkg::S_MC;
			end
			btcd_pkg::S_SUM: begin
				state_d = (op_q == btcd_pkg::OP_QUERY) ? btcd_pkg::S_CMP1 : btcd_pkg::S_ND0;
			end
			btcd_pkg::S_CMP1: begin
				if ((count_q != '0) && !alu_lt) state_d = btcd_pkg::S_ND0;
				else state_d = btcd_pkg::S_CMP2;
			end
			btcd_pkg::S_CMP2: state_d = btcd_pkg::S_ND0;
			btcd_pkg::S_ND0:  state_d = (count_q == '0) ? btcd_pkg::S_DONE : btcd_pkg::S_MUL;
			btcd_pkg::S_MUL:  if (k_q == '0) state_d = btcd_pkg::S_D1;
			btcd_pkg::S_D1:   state_d = btcd_pkg::S_TD;
			btcd_pkg::S_TD:   state_d = btcd_pkg::S_ABS;
			btcd_pkg::S_ABS:  state_d = btcd_pkg::S_DIV;
			btcd_pkg::S_DIV:  if (dk_q == '0) state_d = btcd_pkg::S_UNC;
			btcd_pkg::S_UNC:  state_d = btcd_pkg::S_DC;
			btcd_pkg::S_DC:   state_d = btcd_pkg::S_UC;
			btcd_pkg::S_UC:   state_d = btcd_pkg::S_CL1;
			btcd_pkg::S_CL1:  state_d = btcd_pkg::S_CL2;
			btcd_pkg::S_CL2:  state_d = btcd_pkg::S_CL3;
			btcd_pkg::S_CL3:  state_d = btcd_pkg::S_CL4;
			btcd_pkg::S_CL4:  state_d = btcd_pkg::S_DONE;
			btcd_pkg::S_DONE: if (res_take) state_d = btcd_pkg::S_IDLE;
			default:          state_d = btcd_pkg::S_IDLE;
		endcase
	end

	// operand select for the shared unit and the ring read address
	always_comb begin
		alu_req.op = btcd_pkg::ALU_ADD;
		alu_req.a  = '0;
		alu_req.b  = '0;
		ring_raddr = i_q;
		case (state_q)
			btcd_pkg::S_UPD: begin
				alu_req.a = XW'(count_q);
				alu_req.b = XW'(1);
			end
			btcd_pkg::S_MC: ring_raddr = i_q;
			btcd_pkg::S_ML: ring_raddr = '0;
			btcd_pkg::S_MS: begin
				ring_raddr = (j_q == IW'(W - 1)) ? '0 : (j_q + IW'(1));
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = XW'(ring_rdata);
				alu_req.b  = XW'(cand_q);
			end
			btcd_pkg::S_SUM: begin
				alu_req.a = XW'(now_q);
				alu_req.b = XW'(cfg.future_drift);
			end
			btcd_pkg::S_CMP1: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = XW'(med_q);
				alu_req.b  = XW'(bt_q);
			end
			btcd_pkg::S_CMP2: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = sum_q;
				alu_req.b  = XW'(bt_q);
			end
			btcd_pkg::S_ND0: begin
				// count + ~anchor = count - 1 - anchor, modulo 2^40
				alu_req.a = XW'(count_q);
				alu_req.b = XW'(~anc_i_q);
			end
			btcd_pkg::S_MUL: begin
				alu_req.a = {acc_q[XW-2:0], 1'b0};
				alu_req.b = cfg.spacing[k_q] ? XW'(nn_q) : '0;
			end
			btcd_pkg::S_D1: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = XW'(last_t_q);
				alu_req.b  = XW'(anc_t_q);
			end
			btcd_pkg::S_TD: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = td_q;
				alu_req.b  = acc_q;
			end
			btcd_pkg::S_ABS: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.b  = td_q;
			end
			btcd_pkg::S_DIV: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = XW'(div_t);
				alu_req.b  = XW'(cfg.half_life);
			end
			btcd_pkg::S_UNC: begin
				alu_req.op = neg_q ? btcd_pkg::ALU_ADD : btcd_pkg::ALU_SUB;
				alu_req.a  = XW'(adiff);
				alu_req.b  = XW'(adj_mag);
			end
			btcd_pkg::S_DC: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = XW'(last_d_q);
				alu_req.b  = XW'({cfg.down_steps, 16'b0});
			end
			btcd_pkg::S_UC: begin
				alu_req.a = XW'(last_d_q);
				alu_req.b = XW'({cfg.up_steps, 16'b0});
			end
			btcd_pkg::S_CL1: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = unc_q;
				alu_req.b  = r_q;
			end
			btcd_pkg::S_CL2: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = r_q;
				alu_req.b  = dc_q;
			end
			btcd_pkg::S_CL3: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = XW'(cfg.max_diff);
				alu_req.b  = r_q;
			end
			btcd_pkg::S_CL4: begin
				alu_req.op = btcd_pkg::ALU_SUB;
				alu_req.a  = r_q;
				alu_req.b  = XW'(cfg.min_diff);
			end
			default: ring_raddr = i_q;
		endcase
	end

	// control and chain state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= btcd_pkg::S_IDLE;
			ptr_q    <= '0;
			count_q  <= '0;
			epc_q    <= '0;
			last_t_q <= '0;
			last_d_q <= '0;
			anc_t_q  <= '0;
			anc_d_q  <= '0;
			anc_i_q  <= '0;
		end else begin
			state_q <= state_d;
			if ((state_q == btcd_pkg::S_UPD) && (op_q == btcd_pkg::OP_APPEND)) begin
				ptr_q <= (ptr_q == IW'(W - 1)) ? '0 : (ptr_q + IW'(1));
				if ((count_q == '0) || (epc_q == EW'(EPOCH_BLOCKS - 1))) begin
					anc_t_q <= bt_q;
					anc_d_q <= bd_q;
					anc_i_q <= count_q;
				end
				last_t_q <= bt_q;
				last_d_q <= bd_q;
				count_q  <= alu_sum[TW-1:0];
				// restart the epoch phase at its end and when the count wraps
				if ((epc_q == EW'(EPOCH_BLOCKS - 1)) || (count_q == {TW{1'b1}})) begin
					epc_q <= '0;
				end else begin
					epc_q <= epc_q + EW'(1);
				end
			end
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		case (state_q)
			btcd_pkg::S_IDLE: begin
				op_q  <= in_op;
				bt_q  <= in_bt;
				bd_q  <= in_bd;
				now_q <= in_now;
			end
			btcd_pkg::S_UPD: i_q <= '0;
			btcd_pkg::S_MC: if (count_q == '0) med_q <= '0;
			btcd_pkg::S_ML: begin
				cand_q <= ring_rdata;
				j_q    <= '0;
				cnt_q  <= '0;
			end
			btcd_pkg::S_MS: begin
				// stable rank: smaller, or equal at a lower slot
				if (live_j && (alu_lt || ((ring_rdata == cand_q) && (j_q < i_q)))) begin
					cnt_q <= cnt_q + NW'(1);
				end
				if (j_q != IW'(W - 1)) j_q <= j_q + IW'(1);
			end
			btcd_pkg::S_ME: begin
				if (live_i && (cnt_q == (nwin >> 1))) med_q <= cand_q;
				else i_q <= i_q + IW'(1);
			end
			btcd_pkg::S_SUM: begin
				sum_q  <= alu_sum;
				stat_q <= btcd_pkg::TS_OK;
			end
			btcd_pkg::S_CMP1: if ((count_q != '0) && !alu_lt) stat_q <= btcd_pkg::TS_OLD;
			btcd_pkg::S_CMP2: stat_q <= alu_lt ? btcd_pkg::TS_NEW : btcd_pkg::TS_OK;
			btcd_pkg::S_ND0: begin
				nn_q  <= alu_sum[TW-1:0];
				acc_q <= '0;
				k_q   <= 5'(btcd_pkg::SPACING_W - 1);
				r_q   <= XW'(cfg.genesis);
			end
			btcd_pkg::S_MUL: begin
				acc_q <= alu_sum;
				if (k_q != '0) k_q <= k_q - 5'd1;
			end
			btcd_pkg::S_D1: td_q <= alu_sum;
			btcd_pkg::S_TD: td_q <= alu_sum;
			btcd_pkg::S_ABS: begin
				neg_q <= td_q[XW-1];
				dvd_q <= td_q[XW-1] ? {alu_sum[XW-2:0], 16'b0} : {td_q[XW-2:0], 16'b0};
				rem_q <= '0;
				quo_q <= '0;
				sat_q <= 1'b0;
				dk_q  <= 7'(VW - 1);
			end
			btcd_pkg::S_DIV: begin
				// restoring step: one quotient bit per cycle
				rem_q <= alu_lt ? div_t[31:0] : alu_sum[31:0];
				quo_q <= {quo_q[QW-2:0], !alu_lt};
				sat_q <= sat_q | quo_q[QW-1];
				dvd_q <= {dvd_q[VW-2:0], 1'b0};
				if (dk_q != '0) dk_q <= dk_q - 7'd1;
			end
			btcd_pkg::S_UNC: unc_q <= alu_sum;
			btcd_pkg::S_DC:  dc_q  <= alu_sum;
			btcd_pkg::S_UC:  r_q   <= alu_sum;
			btcd_pkg::S_CL1: if (alu_lt) r_q <= unc_q;
			btcd_pkg::S_CL2: if (alu_lt) r_q <= dc_q;
			btcd_pkg::S_CL3: if (alu_lt) r_q <= XW'(cfg.max_diff);
			btcd_pkg::S_CL4: if (alu_lt) r_q <= XW'(cfg.min_diff);
			default: op_q <= op_q;
		endcase
	end

endmodule

/* rtl/block_time_check_and_difficulty_core.sv */
`timescale 1ns / 1ps
// Top level: configuration registers, result register and the sequenced core.
//
//  channel  signals                        word
//  s        s_tvalid s_tready s_tdata/user append or query item
//  m        m_tvalid m_tready m_tdata      median, status, next difficulty
//  cfg      cfg_we cfg_index cfg_data      register write, no read-back
//
// The time an item takes is set by the rank scan through the single ring read
// port, which tries 1..W median candidates (W = MEDIAN_WINDOW), and by the
// 79-step divider in the shared add/subtract unit.
// An empty chain skips the ASERT step and the divider.
// Reset is asynchronous; no clearing pass is needed.
// s_tready is high while the sequencer is idle; a result held on m waits in
// its own register and does not block the next item.
module block_time_check_and_difficulty_core #(
	parameter int unsigned MEDIAN_WINDOW = btcd_pkg::MEDIAN_WINDOW_DEF,
	parameter int unsigned EPOCH_BLOCKS  = btcd_pkg::EPOCH_BLOCKS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// block_time[39:0], block_difficulty[71:40], now_time[111:72]
	input  logic [111:0]                        s_tdata,
	// operation[0]
	input  logic [0:0]                          s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// median_time[39:0], time_status[41:40], next_difficulty[73:42], zero pad
	output logic [79:0]                         m_tdata,
	input  logic                                cfg_we,
	input  logic [btcd_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [btcd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	btcd_pkg::cfg_t cfg_q;
	btcd_pkg::res_t core_res, out_q;
	logic           out_v_q;
	logic           res_valid;
	logic           res_take;

	assign res_take = !out_v_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spacing      <= btcd_pkg::SPACING_W'(600);
			cfg_q.half_life    <= 32'd172800;
			cfg_q.down_steps   <= btcd_pkg::STEPS_W'(1);
			cfg_q.up_steps     <= btcd_pkg::STEPS_W'(1);
			cfg_q.min_diff     <= '0;
			cfg_q.max_diff     <= '1;
			cfg_q.future_drift <= 32'd7200;
			cfg_q.genesis      <= btcd_pkg::DIFF_W'(65536);
		end else if (cfg_we) begin
			case (btcd_pkg::cfg_idx_t'(cfg_index))
				btcd_pkg::CFG_SPACING:
					cfg_q.spacing <= cfg_data[btcd_pkg::SPACING_W-1:0];
				btcd_pkg::CFG_HALF_LIFE:    cfg_q.half_life    <= cfg_data;
				btcd_pkg::CFG_DOWN_STEPS:   cfg_q.down_steps   <= cfg_data[btcd_pkg::STEPS_W-1:0];
				btcd_pkg::CFG_UP_STEPS:     cfg_q.up_steps     <= cfg_data[btcd_pkg::STEPS_W-1:0];
				btcd_pkg::CFG_MIN_DIFF:     cfg_q.min_diff     <= cfg_data;
				btcd_pkg::CFG_MAX_DIFF:     cfg_q.max_diff     <= cfg_data;
				btcd_pkg::CFG_FUTURE_DRIFT: cfg_q.future_drift <= cfg_data;
				btcd_pkg::CFG_GENESIS:      cfg_q.genesis      <= cfg_data;
				default:                    cfg_q <= cfg_q;
			endcase
		end
	end

	btcd_core #(
		.MEDIAN_WINDOW (MEDIAN_WINDOW),
		.EPOCH_BLOCKS  (EPOCH_BLOCKS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_op     (s_tuser[0]),
		.in_bt     (s_tdata[39:0]),
		.in_bd     (s_tdata[71:40]),
		.in_now    (s_tdata[111:72]),
		.res_take  (res_take),
		.res_valid (res_valid),
		.res       (core_res)
	);

	// hold the result word until the sink takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (res_take) begin
			out_v_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take && res_valid) begin
			out_q <= core_res;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {6'b0, out_q.difficulty, out_q.status, out_q.median};

endmodule

/* bench/tb_block_time_check_and_difficulty_core.sv */
`timescale 1ns / 1ps
// Self-checking bench for the block time check and difficulty core.
module tb_block_time_check_and_difficulty_core;

	localparam int unsigned WIN   = btcd_pkg::MEDIAN_WINDOW_DEF;
	localparam int unsigned EPOCH = btcd_pkg::EPOCH_BLOCKS_DEF;
	localparam longint unsigned M40 = 64'hFF_FFFF_FFFF;
	localparam longint unsigned M32 = 64'hFFFF_FFFF;
	localparam longint unsigned QONE = 65536;

	typedef struct {
		logic                        op;
		logic [btcd_pkg::TIME_W-1:0] bt;
		logic [btcd_pkg::DIFF_W-1:0] bd;
		logic [btcd_pkg::TIME_W-1:0] now;
	} block_item_t;

	typedef struct {
		logic [btcd_pkg::TIME_W-1:0] median;
		logic [1:0]                  status;
		logic [btcd_pkg::DIFF_W-1:0] difficulty;
	} block_res_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [111:0]                    s_tdata;
	logic [0:0]                      s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [79:0]                     m_tdata;
	logic                            cfg_we;
	logic [btcd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [btcd_pkg::CFG_DATA_W-1:0] cfg_data;

	block_item_t pending_items[$];
	block_res_t  expected_results[$];
	block_item_t held_item;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic        hold_ask;
	logic        hold_taken;
	int unsigned hold_cnt;
	int unsigned mismatch_cnt;

	// predictor copy of configuration and chain state
	longint unsigned p_spacing, p_half_life, p_down, p_up, p_min, p_max, p_drift, p_genesis;
	longint unsigned ring[WIN];
	longint unsigned ring_ptr, chain_count, last_time, last_diff;
	longint unsigned anc_time, anc_diff, anc_index;
	longint unsigned time_base;

	block_time_check_and_difficulty_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic longint unsigned window_median();
		longint unsigned v[WIN];
		longint unsigned x, p;
		int n, i, j;
		n = (chain_count < WIN) ? int'(chain_count) : WIN;
		if (n == 0) return 0;
		p = ring_ptr;
		for (i = 0; i < n; i++) begin
			p = (p + WIN - 1) % WIN;
			v[i] = ring[p];
		end
		for (i = 1; i < n; i++) begin
			x = v[i];
			j = i;
			while (j > 0 && v[j-1] > x) begin
				v[j] = v[j-1];
				j--;
			end
			v[j] = x;
		end
		return v[n/2];
	endfunction

	function automatic longint unsigned asert_difficulty();
		longint signed d1, td, adj, unc, dc, uc, r;
		longint unsigned n, prod, mag, q, rem, adiff;
		logic neg;
		if (chain_count == 0) return p_genesis & M32;
		adiff = (anc_diff != 0) ? anc_diff : last_diff;
		n = ((chain_count - 1) - anc_index) & M40;
		prod = n * p_spacing;
		d1 = longint'(last_time) - longint'(anc_time);
		td = d1 - longint'(prod);
		neg = td < 0;
		mag = neg ? (64'd0 - longint'(td)) : longint'(td);
		if (p_half_life == 0) begin
			q = 64'd1 << 34;
			rem = 0;
		end else begin
			q = mag / p_half_life;
			rem = mag % p_half_life;
			if (q > (64'd1 << 34)) q = 64'd1 << 34;
			rem = (rem * QONE) / p_half_life;
		end
		adj = longint'(q * QONE + rem);
		if (neg) adj = -adj;
		unc = longint'(adiff) - adj;
		dc = longint'(last_diff) - longint'(QONE * p_down);
		uc = longint'(last_diff) + longint'(QONE * p_up);
		r = (unc < uc) ? unc : uc;
		if (r < dc) r = dc;
		if (r > longint'(p_max)) r = longint'(p_max);
		if (r < longint'(p_min)) r = longint'(p_min);
		return longint'(r) & M32;
	endfunction

	function automatic block_res_t predict_block(block_item_t it);
		block_res_t res;
		longint unsigned idx, med;
		res.status = btcd_pkg::TS_OK;
		if (it.op == btcd_pkg::OP_APPEND) begin
			idx = chain_count;
			ring[ring_ptr] = it.bt;
			ring_ptr = (ring_ptr + 1) % WIN;
			if (idx == 0 || ((idx + 1) % EPOCH) == 0) begin
				anc_time  = it.bt;
				anc_diff  = it.bd;
				anc_index = idx;
			end
			last_time = it.bt;
			last_diff = it.bd;
			chain_count = (chain_count + 1) & M40;
			med = window_median();
		end else begin
			med = window_median();
			if (chain_count != 0 && longint'(it.bt) <= med) res.status = btcd_pkg::TS_OLD;
			else if (longint'(it.bt) > longint'(it.now) + p_drift)
				res.status = btcd_pkg::TS_NEW;
		end
		res.median = med;
		res.difficulty = asert_difficulty();
		return res;
	endfunction

	// driver: hold the word until accepted, then advance
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tuser  <= '0;
		end else if (!s_tvalid || s_tready) begin
			if (s_tvalid) expected_results = {expected_results, predict_block(held_item)};
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				held_item = pending_items.pop_front();
				s_tvalid <= 1'b1;
				s_tdata  <= {held_item.now, held_item.bd, held_item.bt};
				s_tuser  <= held_item.op;
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	// monitor and receiver
	always @(posedge clk or negedge arst_n) begin
		block_res_t exp_r;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			hold_cnt   <= 0;
			hold_taken <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10) $display("unexpected word %h", m_tdata);
				end else begin
					exp_r = expected_results.pop_front();
					if (m_tdata[39:0] !== exp_r.median || m_tdata[41:40] !== exp_r.status ||
					    m_tdata[73:42] !== exp_r.difficulty) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("mismatch: exp med %h st %0d diff %h, got med %h st %0d diff %h",
								exp_r.median, exp_r.status, exp_r.difficulty,
								m_tdata[39:0], m_tdata[41:40], m_tdata[73:42]);
					end
				end
			end
			if (hold_ask && !hold_taken) begin
				hold_taken <= 1'b1;
				hold_cnt   <= 3000;
				m_tready   <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic write_reg(btcd_pkg::cfg_idx_t idx, longint unsigned val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val[31:0];
		case (idx)
			btcd_pkg::CFG_SPACING:      p_spacing   = val & 64'hF_FFFF;
			btcd_pkg::CFG_HALF_LIFE:    p_half_life = val & M32;
			btcd_pkg::CFG_DOWN_STEPS:   p_down      = val & 64'hFF;
			btcd_pkg::CFG_UP_STEPS:     p_up        = val & 64'hFF;
			btcd_pkg::CFG_MIN_DIFF:     p_min       = val & M32;
			btcd_pkg::CFG_MAX_DIFF:     p_max       = val & M32;
			btcd_pkg::CFG_FUTURE_DRIFT: p_drift     = val & M32;
			default:                    p_genesis   = val & M32;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_all(longint unsigned sp, longint unsigned hl, longint unsigned dn,
	                         longint unsigned up, longint unsigned mn, longint unsigned mx,
	                         longint unsigned dr, longint unsigned gen);
		write_reg(btcd_pkg::CFG_SPACING, sp);
		write_reg(btcd_pkg::CFG_HALF_LIFE, hl);
		write_reg(btcd_pkg::CFG_DOWN_STEPS, dn);
		write_reg(btcd_pkg::CFG_UP_STEPS, up);
		write_reg(btcd_pkg::CFG_MIN_DIFF, mn);
		write_reg(btcd_pkg::CFG_MAX_DIFF, mx);
		write_reg(btcd_pkg::CFG_FUTURE_DRIFT, dr);
		write_reg(btcd_pkg::CFG_GENESIS, gen);
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	function automatic block_item_t mk(logic op, longint unsigned bt, longint unsigned bd,
	                                   longint unsigned now);
		block_item_t it;
		it.op  = op;
		it.bt  = bt;
		it.bd  = bd;
		it.now = now;
		return it;
	endfunction

	task automatic add_item(block_item_t it);
		pending_items = {pending_items, it};
	endtask

	function automatic longint unsigned rand40();
		return {$urandom_range(255), $urandom()} & M40;
	endfunction

	// mostly a plausible chain with random content, the rest noise
	task automatic add_random(int count);
		longint unsigned bt, bd, now, med, sp;
		int k;
		for (k = 0; k < count; k++) begin
			if ($urandom_range(99) < 20) begin
				add_item(mk(1'($urandom_range(1)), rand40(), $urandom(), rand40()));
			end else if ($urandom_range(99) < 65) begin
				sp = (p_spacing > 5000) ? 5000 : p_spacing;
				time_base += sp;
				bt = time_base + $urandom_range(2 * sp) - sp + 1;
				bd = ($urandom_range(9) == 0) ? $urandom() :
				     (last_diff + ($urandom_range(6) * QONE) - 3 * QONE +
				      $urandom_range(65535)) & M32;
				add_item(mk(btcd_pkg::OP_APPEND, bt & M40, bd, rand40()));
			end else begin
				med = time_base;
				bt = med + $urandom_range(8) - 4;
				case ($urandom_range(2))
					0: now = bt;
					1: now = bt - p_drift + $urandom_range(4) - 2;
					default: now = rand40();
				endcase
				add_item(mk(btcd_pkg::OP_QUERY, bt & M40, $urandom(), now & M40));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_ask = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		mismatch_cnt = 0;
		p_spacing = 600; p_half_life = 172800; p_down = 1; p_up = 1;
		p_min = 0; p_max = M32; p_drift = 7200; p_genesis = 65536;
		foreach (ring[i]) ring[i] = 0;
		ring_ptr = 0; chain_count = 0; last_time = 0; last_diff = 0;
		anc_time = 0; anc_diff = 0; anc_index = 0;
		time_base = 1000000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_all(600, 172800, 1, 1, 0, M32, 7200, 65536);
		// empty chain queries: genesis difficulty, too-old skipped
		add_item(mk(btcd_pkg::OP_QUERY, 0, 0, 0));
		add_item(mk(btcd_pkg::OP_QUERY, M40, M32, 0));
		add_item(mk(btcd_pkg::OP_QUERY, 7200, 0, 0));
		add_item(mk(btcd_pkg::OP_QUERY, 7201, 0, 0));
		// first block with zero difficulty: anchor falls back to last
		add_item(mk(btcd_pkg::OP_APPEND, 1000000, 0, M40));
		add_item(mk(btcd_pkg::OP_APPEND, 1000600, 65536, 0));
		add_item(mk(btcd_pkg::OP_QUERY, 1000000, 0, 1000000));
		add_item(mk(btcd_pkg::OP_QUERY, 1000001, 0, 1000000));
		add_item(mk(btcd_pkg::OP_QUERY, 2000000, 0, 1000000));
		add_item(mk(btcd_pkg::OP_QUERY, M40, 0, M40));
		add_item(mk(btcd_pkg::OP_APPEND, M40, M32, 0));
		add_item(mk(btcd_pkg::OP_APPEND, 0, 0, 0));
		add_item(mk(btcd_pkg::OP_APPEND, 1001200, M32, 0));
		add_item(mk(btcd_pkg::OP_QUERY, 0, 0, 0));
		add_item(mk(btcd_pkg::OP_APPEND, 1001800, 65536, 0));
		add_item(mk(btcd_pkg::OP_APPEND, 1002400, 70000, 0));
		add_item(mk(btcd_pkg::OP_QUERY, 1001200, 0, M40));
		wait_drained();

		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				0: write_all(1, 1, 0, 0, 0, M32, 0, 0);
				1: write_all(20'hF_FFFF, M32, 255, 255, M32, 0, M32, M32);
				2: write_all($urandom_range(1, 1200), $urandom_range(1, 400000),
				             $urandom_range(255), $urandom_range(255), $urandom_range(20000),
				             M32 - $urandom_range(1000), $urandom_range(20000), $urandom());
				3: write_all(600, 172800, 1, 1, 0, M32, 7200, 65536);
				default: write_all($urandom_range(1, 3000), $urandom(), $urandom_range(4),
				                   $urandom_range(4), $urandom_range(65536),
				                   $urandom_range(65536, 1 << 28), $urandom(), $urandom());
			endcase
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
				default: begin send_idle_pct = 33; recv_stall_pct = 33; end
			endcase
			add_random(400);
			if (ph == 0) begin
				@(posedge clk);
				hold_ask <= 1'b1;
			end
			wait_drained();
		end

		if (mismatch_cnt == 0 && expected_results.size() == 0) begin
			$display("tb_block_time_check_and_difficulty_core: done, clean");
		end else begin
			$display("tb_block_time_check_and_difficulty_core: done, errors");
		end
		$finish;
	end

	initial begin
		#60_000_000;
		$display("tb_block_time_check_and_difficulty_core: done, errors");
		$finish;
	end

endmodule
